>>> rtl/lc3_instruction_executor_unit_assert.svh
// Assertion helpers for the executor unit.
`ifndef LC3_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define LC3_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LC3X_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lc3x check failed");

// Next-cycle implication, disabled in reset.
`define LC3X_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lc3x check failed");

`endif

>>> rtl/lc3x_pkg.sv
package lc3x_pkg;

  // Word count of the core memory; a power of two, indexed by the low address bits.
  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam logic [15:0] START_PC_RST = 16'h3000;
  localparam logic [15:0] KBSR_ADDR    = 16'hFE00;
  localparam logic [15:0] KBDR_ADDR    = 16'hFE02;
  localparam logic [15:0] KBSR_READY   = 16'h8000;
  localparam logic [MEM_AW-1:0] KBSR_IDX = KBSR_ADDR[MEM_AW-1:0];
  localparam logic [MEM_AW-1:0] KBDR_IDX = KBDR_ADDR[MEM_AW-1:0];

  localparam logic [7:0] HALT_VECTOR = 8'h25;
  localparam logic [2:0] CC_POS = 3'd1;
  localparam logic [2:0] CC_ZRO = 3'd2;
  localparam logic [2:0] CC_NEG = 3'd4;

  typedef enum logic [3:0] {
    OP_BR   = 4'd0,
    OP_ADD  = 4'd1,
    OP_LD   = 4'd2,
    OP_ST   = 4'd3,
    OP_JSR  = 4'd4,
    OP_AND  = 4'd5,
    OP_LDR  = 4'd6,
    OP_STR  = 4'd7,
    OP_RTI  = 4'd8,
    OP_NOT  = 4'd9,
    OP_LDI  = 4'd10,
    OP_STI  = 4'd11,
    OP_JMP  = 4'd12,
    OP_RES  = 4'd13,
    OP_LEA  = 4'd14,
    OP_TRAP = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2,
    MEM_KBDR  = 2'd3
  } mem_op_t;

  typedef enum logic [1:0] {
    ADDR_PC   = 2'd0,
    ADDR_EA   = 2'd1,
    ADDR_MDR  = 2'd2,
    ADDR_LOAD = 2'd3
  } addr_sel_t;

  typedef struct packed {
    logic      item_ld;
    logic      ir_ld;
    logic      pc_inc;
    logic      rfa_ld;
    logic      rfb_ld;
    logic      exec;
    logic      mdr_ld;
    logic      ld_wb;
    logic      out_ld;
    mem_op_t   mem_op;
    addr_sel_t addr_sel;
  } ctl_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    cmd_step;
    logic    halted;
    logic    kbsr_hit;
    logic    key_ready;
  } dp_stat_t;

endpackage

>>> rtl/lc3x_if.sv
interface lc3x_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] load_address;
  logic [15:0] load_data;
  logic        key_ready;
  logic [7:0]  key_code;
  modport source (output valid, cmd, load_address, load_data, key_ready, key_code,
                  input ready);
  modport sink (input valid, cmd, load_address, load_data, key_ready, key_code,
                output ready);
endinterface

interface lc3x_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc_after;
  logic [2:0]  cond_flags;
  logic        halted;
  logic        trap_taken;
  logic [7:0]  trap_vector;
  logic [15:0] reg_zero_value;
  modport source (output valid, pc_after, cond_flags, halted, trap_taken, trap_vector,
                  reg_zero_value, input ready);
  modport sink (input valid, pc_after, cond_flags, halted, trap_taken, trap_vector,
                reg_zero_value, output ready);
endinterface

interface lc3x_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/lc3_instruction_executor_unit.sv
// LC-3 executor with a private word memory.
// in_ch carries one transaction per item: cmd 0 writes load_data at load_address,
// cmd 1 executes the instruction at PC; key_ready and key_code feed the keyboard
// registers when the instruction or its operand reads the keyboard status word.
// out_ch returns exactly one transaction per item: PC, condition code, halt and trap
// status and R0. cfg_ch loads PC directly with the start address; it is always ready.
// Items are handled one at a time, sequenced over the single memory port; a keyboard
// status read with a key pending first writes the key to the data register, which
// takes its own port access.
// The next item is taken as soon as the result sits in the output register.
// If the receiver stalls, the result is held and the following item waits at its
// final step until the output register frees up.
// Reset clears the register file and trap status, sets PC to 0x3000, the zero flag, and halt off;
// memory contents are not cleared and must be loaded before they are read.
// Once halted, step items return the state unchanged; load items still write.
`include "lc3_instruction_executor_unit_assert.svh"

module lc3_instruction_executor_unit import lc3x_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  lc3x_in_if.sink     in_ch,
  lc3x_out_if.source  out_ch,
  lc3x_cfg_if.sink    cfg_ch
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  lc3x_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lc3x_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_cmd             (in_ch.cmd),
    .in_load_address    (in_ch.load_address),
    .in_load_data       (in_ch.load_data),
    .in_key_ready       (in_ch.key_ready),
    .in_key_code        (in_ch.key_code),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_ch.data),
    .out_pc_after       (out_ch.pc_after),
    .out_cond_flags     (out_ch.cond_flags),
    .out_halted         (out_ch.halted),
    .out_trap_taken     (out_ch.trap_taken),
    .out_trap_vector    (out_ch.trap_vector),
    .out_reg_zero_value (out_ch.reg_zero_value)
  );

  `LC3X_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `LC3X_ASSERT_NEXT(a_halt_sticky, clk, rst_n, stat.halted, stat.halted)
  `LC3X_ASSERT_NOW(a_no_exec_halted, clk, rst_n, cmd.exec || cmd.ir_ld, !stat.halted)

endmodule

>>> rtl/lc3x_datapath.sv
module lc3x_datapath import lc3x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  input  logic        in_cmd,
  input  logic [15:0] in_load_address,
  input  logic [15:0] in_load_data,
  input  logic        in_key_ready,
  input  logic [7:0]  in_key_code,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic [15:0] out_pc_after,
  output logic [2:0]  out_cond_flags,
  output logic        out_halted,
  output logic        out_trap_taken,
  output logic [7:0]  out_trap_vector,
  output logic [15:0] out_reg_zero_value
);

  logic [15:0] mem_r [MEM_WORDS];
  logic [15:0] mem_q_r;
  logic        kb_byp_r;
  logic [15:0] kb_val_r;

  logic [15:0] rf_r [8];
  logic [15:0] pc_r, ir_r, opa_r, opb_r, mdr_r;
  logic [2:0]  cc_r;
  logic        halt_r, trap_r;
  logic [7:0]  vec_r;
  logic        cmd_r, key_ready_r;
  logic [7:0]  key_code_r;
  logic [15:0] load_address_r, load_data_r;

  opcode_t     op;
  logic [15:0] off9, off6, off11, imm5, ea, rdata, mem_addr, mem_wdata, kb_word;
  logic [2:0]  rb_idx;
  logic        rf_we, cc_we, pc_we, trap_set;
  logic [2:0]  rf_wa, cc_nxt;
  logic [15:0] rf_wd, pc_wd;

  assign op    = opcode_t'(ir_r[15:12]);
  assign off9  = {{7{ir_r[8]}}, ir_r[8:0]};
  assign off6  = {{10{ir_r[5]}}, ir_r[5:0]};
  assign off11 = {{5{ir_r[10]}}, ir_r[10:0]};
  assign imm5  = {{11{ir_r[4]}}, ir_r[4:0]};
  assign ea    = (op == OP_LDR || op == OP_STR) ? opa_r + off6 : pc_r + off9;
  assign rdata = kb_byp_r ? kb_val_r : mem_q_r;
  assign rb_idx = (op == OP_ST || op == OP_STI || op == OP_STR) ? ir_r[11:9] : ir_r[2:0];
  assign kb_word = key_ready_r ? KBSR_READY : 16'h0000;

  always_comb begin
    case (cmd.addr_sel)
      ADDR_PC:   mem_addr = pc_r;
      ADDR_EA:   mem_addr = ea;
      ADDR_MDR:  mem_addr = mdr_r;
      ADDR_LOAD: mem_addr = load_address_r;
      default:   mem_addr = pc_r;
    endcase
    mem_wdata = (cmd.addr_sel == ADDR_LOAD) ? load_data_r : opb_r;
  end

  // Single memory port; a read of the keyboard status rewrites it and forwards the new word.
  always_ff @(posedge clk) begin
    case (cmd.mem_op)
      MEM_READ: begin
        kb_byp_r <= (mem_addr == KBSR_ADDR);
        kb_val_r <= kb_word;
        if (mem_addr == KBSR_ADDR) begin
          mem_r[KBSR_IDX] <= kb_word;
        end else begin
          mem_q_r <= mem_r[mem_addr[MEM_AW-1:0]];
        end
      end
      MEM_WRITE: mem_r[mem_addr[MEM_AW-1:0]] <= mem_wdata;
      MEM_KBDR:  mem_r[KBDR_IDX] <= {8'h00, key_code_r};
      default: ;
    endcase
  end

  always_comb begin
    rf_we    = 1'b0;
    rf_wa    = ir_r[11:9];
    rf_wd    = 16'h0000;
    cc_we    = 1'b0;
    pc_we    = 1'b0;
    pc_wd    = pc_r;
    trap_set = 1'b0;
    if (cmd.exec) begin
      case (op)
        OP_ADD: begin
          rf_we = 1'b1; cc_we = 1'b1;
          rf_wd = opa_r + (ir_r[5] ? imm5 : opb_r);
        end
        OP_AND: begin
          rf_we = 1'b1; cc_we = 1'b1;
          rf_wd = opa_r & (ir_r[5] ? imm5 : opb_r);
        end
        OP_NOT: begin
          rf_we = 1'b1; cc_we = 1'b1;
          rf_wd = ~opa_r;
        end
        OP_LEA: begin
          rf_we = 1'b1; cc_we = 1'b1;
          rf_wd = pc_r + off9;
        end
        OP_BR: begin
          pc_we = |(ir_r[11:9] & cc_r);
          pc_wd = pc_r + off9;
        end
        OP_JMP: begin
          pc_we = 1'b1;
          pc_wd = opa_r;
        end
        OP_JSR: begin
          rf_we = 1'b1; rf_wa = 3'd7; rf_wd = pc_r;
          pc_we = 1'b1;
          pc_wd = ir_r[11] ? pc_r + off11 : opa_r;
        end
        OP_RTI, OP_RES, OP_TRAP: begin
          rf_we = 1'b1; rf_wa = 3'd7; rf_wd = pc_r;
          trap_set = 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.ld_wb) begin
      rf_we = 1'b1; cc_we = 1'b1;
      rf_wd = rdata;
    end
    if (rf_wd == 16'h0000) cc_nxt = CC_ZRO;
    else if (rf_wd[15])    cc_nxt = CC_NEG;
    else                   cc_nxt = CC_POS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) rf_r[i] <= 16'h0000;
      pc_r       <= START_PC_RST;
      cc_r       <= CC_ZRO;
      halt_r     <= 1'b0;
      trap_r     <= 1'b0;
      vec_r      <= 8'h00;
    end else begin
      if (rf_we) rf_r[rf_wa] <= rf_wd;
      if (cc_we) cc_r <= cc_nxt;
      if (cfg_we) begin
        pc_r       <= cfg_data;
      end else if (cmd.pc_inc) begin
        pc_r <= pc_r + 16'd1;
      end else if (pc_we) begin
        pc_r <= pc_wd;
      end
      if (cmd.item_ld) begin
        trap_r <= 1'b0;
        vec_r  <= 8'h00;
      end else if (trap_set) begin
        trap_r <= 1'b1;
        vec_r  <= ir_r[7:0];
        if (ir_r[7:0] == HALT_VECTOR) halt_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      cmd_r          <= in_cmd;
      load_address_r <= in_load_address;
      load_data_r    <= in_load_data;
      key_ready_r    <= in_key_ready;
      key_code_r     <= in_key_code;
    end
    if (cmd.ir_ld)  ir_r  <= rdata;
    if (cmd.rfa_ld) opa_r <= rf_r[ir_r[8:6]];
    if (cmd.rfb_ld) opb_r <= rf_r[rb_idx];
    if (cmd.mdr_ld) mdr_r <= rdata;
    if (cmd.out_ld) begin
      out_pc_after       <= pc_r;
      out_cond_flags     <= cc_r;
      out_halted         <= halt_r;
      out_trap_taken     <= trap_r;
      out_trap_vector    <= vec_r;
      out_reg_zero_value <= rf_r[0];
    end
  end

  assign stat.opcode    = op;
  assign stat.cmd_step  = cmd_r;
  assign stat.halted    = halt_r;
  assign stat.kbsr_hit  = (mem_addr == KBSR_ADDR);
  assign stat.key_ready = key_ready_r;

endmodule

>>> rtl/lc3x_controller.sv
module lc3x_controller import lc3x_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_LOAD   = 13'h0002,
    S_FETCH  = 13'h0004,
    S_DECODE = 13'h0008,
    S_RDA    = 13'h0010,
    S_RDB    = 13'h0020,
    S_EXEC   = 13'h0040,
    S_RD1    = 13'h0080,
    S_CAP1   = 13'h0100,
    S_RD2    = 13'h0200,
    S_WB     = 13'h0400,
    S_WR     = 13'h0800,
    S_DONE   = 13'h1000
  } state_t;

  state_t state_r, state_nxt;
  logic   kb_done_r, kb_done_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   kb_first;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // Keyboard data goes in first when a status read sees a pending key.
  assign kb_first  = stat.kbsr_hit && stat.key_ready && !kb_done_r;

  always_comb begin
    state_nxt     = state_r;
    kb_done_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mem_op    = MEM_NONE;
    cmd.addr_sel  = ADDR_PC;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!stat.cmd_step) begin
          cmd.mem_op   = MEM_WRITE;
          cmd.addr_sel = ADDR_LOAD;
          state_nxt    = S_DONE;
        end else if (stat.halted) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.addr_sel = ADDR_PC;
        if (kb_first) begin
          cmd.mem_op  = MEM_KBDR;
          kb_done_nxt = 1'b1;
        end else begin
          cmd.mem_op = MEM_READ;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.ir_ld  = 1'b1;
        cmd.pc_inc = 1'b1;
        state_nxt  = S_RDA;
      end
      S_RDA: begin
        cmd.rfa_ld = 1'b1;
        state_nxt  = S_RDB;
      end
      S_RDB: begin
        cmd.rfb_ld = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        case (stat.opcode)
          OP_LD, OP_LDR, OP_LDI, OP_STI: state_nxt = S_RD1;
          OP_ST, OP_STR:                 state_nxt = S_WR;
          default: begin
            cmd.exec  = 1'b1;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RD1: begin
        cmd.addr_sel = ADDR_EA;
        if (kb_first) begin
          cmd.mem_op  = MEM_KBDR;
          kb_done_nxt = 1'b1;
        end else begin
          cmd.mem_op = MEM_READ;
          state_nxt  = (stat.opcode == OP_LDI || stat.opcode == OP_STI) ? S_CAP1 : S_WB;
        end
      end
      S_CAP1: begin
        cmd.mdr_ld = 1'b1;
        state_nxt  = (stat.opcode == OP_LDI) ? S_RD2 : S_WR;
      end
      S_RD2: begin
        cmd.addr_sel = ADDR_MDR;
        if (kb_first) begin
          cmd.mem_op  = MEM_KBDR;
          kb_done_nxt = 1'b1;
        end else begin
          cmd.mem_op = MEM_READ;
          state_nxt  = S_WB;
        end
      end
      S_WB: begin
        cmd.ld_wb = 1'b1;
        state_nxt = S_DONE;
      end
      S_WR: begin
        cmd.mem_op   = MEM_WRITE;
        cmd.addr_sel = (stat.opcode == OP_STI) ? ADDR_MDR : ADDR_EA;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kb_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kb_done_r   <= kb_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
